FILE: src/rmq_pkg.sv
// Shared types, widths and helpers for the rotation matrix to quaternion pipeline.
package rmq_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 30;
    localparam int RAD_W         = 34;   // trace / radicand, exact sum of three elements
    localparam int NUM_W         = 33;   // pair sum or difference
    localparam int QUO_W         = 32;   // quotient magnitude, at most 2^31 since s >= 2*ONE
    localparam int LANES         = 3;    // off-diagonal components per item

    typedef struct packed {
        logic signed [DATA_W-1:0] r00;
        logic signed [DATA_W-1:0] r01;
        logic signed [DATA_W-1:0] r02;
        logic signed [DATA_W-1:0] r10;
        logic signed [DATA_W-1:0] r11;
        logic signed [DATA_W-1:0] r12;
        logic signed [DATA_W-1:0] r20;
        logic signed [DATA_W-1:0] r21;
        logic signed [DATA_W-1:0] r22;
    } t_mat;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] quat_w;
        logic                     divide_error;
    } t_quat;

    // Which component is the diagonal one (s/4)
    typedef enum logic [1:0] {
        BR_W,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    // Lanes hold the three non-diagonal components in x, y, z, w order.
    typedef struct packed {
        t_branch                        br;
        logic [LANES-1:0][NUM_W-1:0]    num;
    } t_side;

    localparam logic [QUO_W:0] POS_LIM = (QUO_W+1)'((64'd1 << (DATA_W-1)) - 64'd1);
    localparam logic [QUO_W:0] NEG_LIM = (QUO_W+1)'(64'd1 << (DATA_W-1));

    function automatic logic [DATA_W-1:0] sat_out(input logic [QUO_W:0] mag, input logic neg);
        logic [QUO_W:0] negv;
        logic [DATA_W-1:0] res;
        negv = -mag;
        if (!neg) begin
            res = (mag > POS_LIM) ? DATA_W'(POS_LIM) : mag[DATA_W-1:0];
        end else begin
            res = (mag > NEG_LIM) ? DATA_W'(NEG_LIM) : negv[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: src/rmq_front.sv
// Input stage: trace, branch pick, radicand and off-diagonal numerators.
module rmq_front import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_mat             i_mat,
    output logic             o_valid,
    output logic [RAD_W-1:0] o_rad,
    output t_side            o_side
);

    logic signed [RAD_W-1:0] m00, m11, m22, tr, n_rad_s;
    logic signed [RAD_W-1:0] one_v;
    logic signed [NUM_W-1:0] na, nb, nc, nd, ne, nf;
    t_side                   n_side;

    logic                    r_valid;
    logic [RAD_W-1:0]        r_rad;
    t_side                   r_side;

    always_comb begin
        one_v = RAD_W'(1) << FRAC_BITS;
        m00   = RAD_W'(i_mat.r00);
        m11   = RAD_W'(i_mat.r11);
        m22   = RAD_W'(i_mat.r22);
        tr    = m00 + m11 + m22;
        na    = NUM_W'(i_mat.r21) - NUM_W'(i_mat.r12);
        nb    = NUM_W'(i_mat.r02) - NUM_W'(i_mat.r20);
        nc    = NUM_W'(i_mat.r10) - NUM_W'(i_mat.r01);
        nd    = NUM_W'(i_mat.r01) + NUM_W'(i_mat.r10);
        ne    = NUM_W'(i_mat.r02) + NUM_W'(i_mat.r20);
        nf    = NUM_W'(i_mat.r12) + NUM_W'(i_mat.r21);
        if (tr > 0) begin
            n_rad_s       = tr + one_v;
            n_side.br     = BR_W;
            n_side.num[0] = na;
            n_side.num[1] = nb;
            n_side.num[2] = nc;
        end else if (m00 > m11 && m00 > m22) begin
            n_rad_s       = one_v + m00 - m11 - m22;
            n_side.br     = BR_X;
            n_side.num[0] = nd;
            n_side.num[1] = ne;
            n_side.num[2] = na;
        end else if (m11 > m22) begin
            n_rad_s       = one_v + m11 - m00 - m22;
            n_side.br     = BR_Y;
            n_side.num[0] = nd;
            n_side.num[1] = nf;
            n_side.num[2] = nb;
        end else begin
            n_rad_s       = one_v + m22 - m00 - m11;
            n_side.br     = BR_Z;
            n_side.num[0] = ne;
            n_side.num[1] = nf;
            n_side.num[2] = nc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad_s;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

FILE: src/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage, side data carried along.
module rmq_sqrt import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ROOT_W    = (RAD_W + FRAC_BITS + 1) / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [X_W-1:0]    s_x    [ROOT_W];
    logic [REM_W-1:0]  s_rem  [ROOT_W];
    logic [ROOT_W-1:0] s_root [ROOT_W+1];
    logic              s_v    [ROOT_W+1];
    t_side             s_side [ROOT_W+1];

    assign s_x[0]    = X_W'({i_rad, {FRAC_BITS{1'b0}}});
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_v[0]    = i_valid;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_sh, trial;
        logic              ge;
        logic [ROOT_W-1:0] n_root;
        logic              r_v;
        logic [ROOT_W-1:0] r_root;
        t_side             r_side;

        always_comb begin
            rem_sh = {s_rem[k][REM_W-3:0], s_x[k][X_W-1 -: 2]};
            trial  = {s_root[k], 2'b01};
            ge     = (rem_sh >= trial);
            n_root = {s_root[k][ROOT_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root <= n_root;
                r_side <= s_side[k];
            end
        end

        assign s_v[k+1]    = r_v;
        assign s_root[k+1] = r_root;
        assign s_side[k+1] = r_side;

        if (k < ROOT_W - 1) begin : g_fwd
            logic [REM_W-1:0] n_rem, r_rem;
            logic [X_W-1:0]   r_x;
            assign n_rem = ge ? (rem_sh - trial) : rem_sh;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_rem;
                    r_x   <= s_x[k] << 2;
                end
            end
            assign s_rem[k+1] = r_rem;
            assign s_x[k+1]   = r_x;
        end
    end

    assign o_valid = s_v[ROOT_W];
    assign o_root  = s_root[ROOT_W];
    assign o_side  = s_side[ROOT_W];

endmodule

FILE: src/rmq_div.sv
// Three-lane pipelined restoring divider sharing one divisor s = 2*root.
module rmq_div import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ROOT_W    = (RAD_W + FRAC_BITS + 1) / 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ROOT_W-1:0]           i_root,
    input  t_side                       i_side,
    output logic                        o_valid,
    output logic [ROOT_W:0]             o_divisor,
    output t_branch                     o_br,
    output logic [LANES-1:0]            o_neg,
    output logic [LANES-1:0][QUO_W-1:0] o_quo
);

    localparam int S_W = ROOT_W + 1;
    localparam int D_W = NUM_W + FRAC_BITS + 1;

    // per-stage inputs; index 0 is the prep register
    logic                        s_v   [QUO_W+1];
    logic [S_W-1:0]              s_div [QUO_W+1];
    t_branch                     s_br  [QUO_W+1];
    logic [LANES-1:0]            s_neg [QUO_W+1];
    logic [LANES-1:0][QUO_W-1:0] s_q   [QUO_W+1];
    logic [LANES-1:0][S_W-1:0]   s_r   [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] s_d   [QUO_W];

    // prep: magnitude, rounding offset (s/2 = root), split dividend
    logic [LANES-1:0]            n_neg;
    logic [LANES-1:0][S_W-1:0]   n_r0;
    logic [LANES-1:0][QUO_W-1:0] n_d0;
    logic [NUM_W-1:0]            mag;
    logic [D_W-1:0]              dvd;

    logic                        r_pv;
    logic [S_W-1:0]              r_pdiv;
    t_branch                     r_pbr;
    logic [LANES-1:0]            r_pneg;
    logic [LANES-1:0][S_W-1:0]   r_pr;
    logic [LANES-1:0][QUO_W-1:0] r_pd;

    always_comb begin
        mag = '0;
        dvd = '0;
        for (int l = 0; l < LANES; l++) begin
            n_neg[l] = i_side.num[l][NUM_W-1];
            mag      = n_neg[l] ? (NUM_W'(0) - i_side.num[l]) : i_side.num[l];
            dvd      = (D_W'(mag) << FRAC_BITS) + D_W'(i_root);
            n_r0[l]  = S_W'(dvd >> QUO_W);
            n_d0[l]  = dvd[QUO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pdiv <= {i_root, 1'b0};
            r_pbr  <= i_side.br;
            r_pneg <= n_neg;
            r_pr   <= n_r0;
            r_pd   <= n_d0;
        end
    end

    assign s_v[0]   = r_pv;
    assign s_div[0] = r_pdiv;
    assign s_br[0]  = r_pbr;
    assign s_neg[0] = r_pneg;
    assign s_q[0]   = '0;
    assign s_r[0]   = r_pr;
    assign s_d[0]   = r_pd;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [LANES-1:0][S_W:0]     rs;
        logic [LANES-1:0]            ge;
        logic [LANES-1:0][QUO_W-1:0] n_q;
        logic                        r_v;
        logic [S_W-1:0]              r_div;
        t_branch                     r_br;
        logic [LANES-1:0]            r_neg;
        logic [LANES-1:0][QUO_W-1:0] r_q;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                rs[l]  = {s_r[k][l], s_d[k][l][QUO_W-1]};
                ge[l]  = (rs[l] >= {1'b0, s_div[k]});
                n_q[l] = {s_q[k][l][QUO_W-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div <= s_div[k];
                r_br  <= s_br[k];
                r_neg <= s_neg[k];
                r_q   <= n_q;
            end
        end

        assign s_v[k+1]   = r_v;
        assign s_div[k+1] = r_div;
        assign s_br[k+1]  = r_br;
        assign s_neg[k+1] = r_neg;
        assign s_q[k+1]   = r_q;

        if (k < QUO_W - 1) begin : g_fwd
            logic [LANES-1:0][S_W:0]     diff;
            logic [LANES-1:0][S_W-1:0]   n_r;
            logic [LANES-1:0][QUO_W-1:0] r_d;
            logic [LANES-1:0][S_W-1:0]   r_r;
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    diff[l] = rs[l] - {1'b0, s_div[k]};
                    n_r[l]  = ge[l] ? diff[l][S_W-1:0] : rs[l][S_W-1:0];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r <= n_r;
                    r_d <= s_d[k] << 1;
                end
            end
            assign s_r[k+1] = r_r;
            assign s_d[k+1] = r_d;
        end
    end

    assign o_valid   = s_v[QUO_W];
    assign o_divisor = s_div[QUO_W];
    assign o_br      = s_br[QUO_W];
    assign o_neg     = s_neg[QUO_W];
    assign o_quo     = s_q[QUO_W];

endmodule

FILE: src/rotation_matrix_to_quaternion_top.sv
// Top level: rotation matrix (Q2.30) to quaternion, four-branch trace method, fully pipelined.
//
// One matrix beat in, one quaternion beat out, at a sustained one beat per clock while the
// sink takes every beat. The pipe is one input register (trace, branch pick, radicand,
// numerators), ROOT_W square-root stages producing one root bit each, one divider prep
// register, QUO_W restoring-divide stages (one quotient bit each, three lanes sharing the
// divisor s = 2*root), and an output register doing the diagonal term (r+1)>>1, sign
// restore, saturation and component placement. All stages share one advance enable: the
// pipe moves whenever the output register is empty or its beat is being taken, so
// o_in_ready drops only while a finished beat waits downstream. Quotients round to
// nearest, ties away from zero. The radicand is never below ONE, so the divisor is never
// zero and divide_error reads 0 in practice.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_mat  i_in_data,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_quat o_out_data
);

    localparam int ROOT_W = (RAD_W + FRAC_BITS + 1) / 2;

    logic                        en;

    // front -> sqrt
    logic                        f_valid;
    logic [RAD_W-1:0]            f_rad;
    t_side                       f_side;

    // sqrt -> divider
    logic                        q_valid;
    logic [ROOT_W-1:0]           q_root;
    t_side                       q_side;

    // divider -> output
    logic                        d_valid;
    logic [ROOT_W:0]             d_divisor;
    t_branch                     d_br;
    logic [LANES-1:0]            d_neg;
    logic [LANES-1:0][QUO_W-1:0] d_quo;

    // output assembly
    logic [ROOT_W-1:0]           root_e;
    logic [ROOT_W:0]             root_p1;
    logic [DATA_W-1:0]           diag;
    logic [LANES-1:0][DATA_W-1:0] lane;
    t_quat                       n_out;

    logic                        r_out_valid;
    t_quat                       r_out;
    t_branch                     r_out_br;

    // whole pipe advances unless a result is stuck in the output register
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_mat   (i_in_data),
        .o_valid (f_valid),
        .o_rad   (f_rad),
        .o_side  (f_side)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_rad   (f_rad),
        .i_side  (f_side),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (q_valid),
        .i_root    (q_root),
        .i_side    (q_side),
        .o_valid   (d_valid),
        .o_divisor (d_divisor),
        .o_br      (d_br),
        .o_neg     (d_neg),
        .o_quo     (d_quo)
    );

    always_comb begin
        root_e  = d_divisor[ROOT_W:1];
        root_p1 = {1'b0, root_e} + (ROOT_W+1)'(1);
        // diagonal term: r/2 rounded half up, clipped to the positive limit
        diag    = sat_out((QUO_W+1)'(root_p1 >> 1), 1'b0);
        for (int l = 0; l < LANES; l++) begin
            lane[l] = sat_out({1'b0, d_quo[l]}, d_neg[l]);
        end
        n_out.divide_error = (d_divisor == '0);
        case (d_br)
            BR_W: begin
                n_out.quat_x = lane[0];
                n_out.quat_y = lane[1];
                n_out.quat_z = lane[2];
                n_out.quat_w = diag;
            end
            BR_X: begin
                n_out.quat_x = diag;
                n_out.quat_y = lane[0];
                n_out.quat_z = lane[1];
                n_out.quat_w = lane[2];
            end
            BR_Y: begin
                n_out.quat_x = lane[0];
                n_out.quat_y = diag;
                n_out.quat_z = lane[1];
                n_out.quat_w = lane[2];
            end
            default: begin
                n_out.quat_x = lane[0];
                n_out.quat_y = lane[1];
                n_out.quat_z = diag;
                n_out.quat_w = lane[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && d_valid) begin
            r_out    <= n_out;
            r_out_br <= d_br;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // divisor is at least 2*ONE, so the zero-divisor path never fires
    a_no_div_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_out_data.divide_error)
        else $error("divide_error raised");

    // the diagonal component is s/4 and never negative
    a_diag_w_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_br == BR_W) |-> !o_out_data.quat_w[DATA_W-1])
        else $error("negative diagonal w");

    a_diag_x_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_br == BR_X) |-> !o_out_data.quat_x[DATA_W-1])
        else $error("negative diagonal x");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

FILE: verif/rotation_matrix_to_quaternion_top_tb.sv
// Testbench for the rotation matrix to quaternion pipeline: directed and random matrices.
module rotation_matrix_to_quaternion_top_tb;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FB         = FRAC_BITS_DEF;
    localparam longint ONE        = 64'sd1 <<< FB;
    localparam longint QMAX       = 64'sd2147483647;
    localparam longint QMIN       = -64'sd2147483648;
    localparam int     LATENCY    = 3 + 34 + QUO_W;   // generous drain allowance
    localparam int     STALL_LIMIT = 2000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_mat  i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_quat o_out_data;

    rotation_matrix_to_quaternion_top #(.FRAC_BITS(FB)) dut (.*);

    always #5 i_clk = ~i_clk;

    t_quat  quat_fifo[$];
    int     mismatch_cnt = 0;
    int     beats_in = 0;
    int     beats_out = 0;
    int     idle_cycles = 0;
    int     sink_stall = 0;     // remaining cycles of a sink stall burst
    bit     no_idle = 1'b0;     // last phase: both sides run flat out
    bit     sink_on = 1'b0;

    // Integer square root, floor, bit by bit.
    function automatic longint isqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint clip32(longint v);
        return (v > QMAX) ? QMAX : (v < QMIN) ? QMIN : v;
    endfunction

    // num*ONE/s, nearest with ties away from zero; zero divisor saturates.
    function automatic longint div_round(longint num, longint s, inout bit err);
        longint unsigned mag, q;
        if (s <= 0) begin
            err = 1'b1;
            return (num > 0) ? QMAX : (num < 0) ? QMIN : 0;
        end
        mag = (num < 0) ? longint'(-num) : num;
        q = ((mag << FB) + (longint'(s) >> 1)) / longint'(s);
        if (q > (64'd1 << 32)) q = 64'd1 << 32;
        return clip32((num < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_quat predict_quat(t_mat m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, r, s, d;
        longint qx, qy, qz, qw;
        bit err;
        t_quat q;
        a00 = m.r00; a01 = m.r01; a02 = m.r02;
        a10 = m.r10; a11 = m.r11; a12 = m.r12;
        a20 = m.r20; a21 = m.r21; a22 = m.r22;
        err = 1'b0;
        tr = a00 + a11 + a22;
        if (tr > 0) r = ONE + tr;
        else if (a00 > a11 && a00 > a22) r = ONE + a00 - a11 - a22;
        else if (a11 > a22) r = ONE + a11 - a00 - a22;
        else r = ONE + a22 - a00 - a11;
        if (r < 0) r = 0;
        r = isqrt(longint'(r) << FB);
        s = 2 * r;
        d = clip32((r + 1) >>> 1);
        if (tr > 0) begin
            qw = d;
            qx = div_round(a21 - a12, s, err);
            qy = div_round(a02 - a20, s, err);
            qz = div_round(a10 - a01, s, err);
        end else if (a00 > a11 && a00 > a22) begin
            qx = d;
            qw = div_round(a21 - a12, s, err);
            qy = div_round(a01 + a10, s, err);
            qz = div_round(a02 + a20, s, err);
        end else if (a11 > a22) begin
            qy = d;
            qw = div_round(a02 - a20, s, err);
            qx = div_round(a01 + a10, s, err);
            qz = div_round(a12 + a21, s, err);
        end else begin
            qz = d;
            qw = div_round(a10 - a01, s, err);
            qx = div_round(a02 + a20, s, err);
            qy = div_round(a12 + a21, s, err);
        end
        q.quat_x = qx[31:0];
        q.quat_y = qy[31:0];
        q.quat_z = qz[31:0];
        q.quat_w = qw[31:0];
        q.divide_error = err;
        return q;
    endfunction

    // Send one matrix beat; random gap before it unless in the flat-out phase.
    task automatic send_mat(t_mat m);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= m;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        quat_fifo = {quat_fifo, predict_quat(m)};
        beats_in++;
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(ONE);
            3: return -32'(ONE);
            4: return 32'($urandom_range(0, 32'(2 * ONE)) - ONE);   // rotation-like range
            default: return $urandom;
        endcase
    endfunction

    function automatic t_mat rand_mat();
        t_mat m;
        m.r00 = rand_elem(); m.r01 = rand_elem(); m.r02 = rand_elem();
        m.r10 = rand_elem(); m.r11 = rand_elem(); m.r12 = rand_elem();
        m.r20 = rand_elem(); m.r21 = rand_elem(); m.r22 = rand_elem();
        return m;
    endfunction

    // Proper rotation about one axis from a random angle, built in real then quantized.
    function automatic t_mat rand_rotation();
        real ax, ay, az, n, th, c, s, t;
        t_mat m;
        ax = $urandom_range(0, 2000) - 1000.0;
        ay = $urandom_range(0, 2000) - 1000.0;
        az = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(ax * ax + ay * ay + az * az);
        if (n == 0.0) begin
            ax = 1.0; n = 1.0;
        end
        ax /= n; ay /= n; az /= n;
        th = ($urandom_range(0, 62831) / 10000.0);
        c = $cos(th); s = $sin(th); t = 1.0 - c;
        m.r00 = $rtoi((t * ax * ax + c) * ONE);
        m.r01 = $rtoi((t * ax * ay - s * az) * ONE);
        m.r02 = $rtoi((t * ax * az + s * ay) * ONE);
        m.r10 = $rtoi((t * ax * ay + s * az) * ONE);
        m.r11 = $rtoi((t * ay * ay + c) * ONE);
        m.r12 = $rtoi((t * ay * az - s * ax) * ONE);
        m.r20 = $rtoi((t * ax * az - s * ay) * ONE);
        m.r21 = $rtoi((t * ay * az + s * ax) * ONE);
        m.r22 = $rtoi((t * az * az + c) * ONE);
        return m;
    endfunction

    function automatic t_mat diag_mat(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
        t_mat m;
        m = '0;
        m.r00 = d0; m.r11 = d1; m.r22 = d2;
        m.r01 = 32'h1234_5678; m.r10 = 32'hF00D_0001;
        m.r02 = 32'h0ABC_DEF0; m.r20 = 32'h8765_4321;
        m.r12 = 32'h7FFF_FFFF; m.r21 = 32'h8000_0000;
        return m;
    endfunction

    // Directed: unit diagonal, each diagonal branch, ties on the diagonal, field extremes.
    task automatic test_directed();
        t_mat m;
        send_mat(diag_mat(32'(ONE), 32'(ONE), 32'(ONE)));
        send_mat(diag_mat(32'(ONE), -32'(ONE), -32'(ONE)));      // x branch
        send_mat(diag_mat(-32'(ONE), 32'(ONE), -32'(ONE)));      // y branch
        send_mat(diag_mat(-32'(ONE), -32'(ONE), 32'(ONE)));      // z branch
        send_mat(diag_mat(0, 0, 0));                             // zero trace, ties -> z
        send_mat(diag_mat(-32'(ONE), -32'(ONE), -32'(ONE)));     // all tie
        send_mat(diag_mat(32'(ONE), 32'(ONE), -32'(2 * ONE)));   // x/y tie -> y
        send_mat(diag_mat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_mat(diag_mat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_mat(diag_mat(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_mat(diag_mat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_mat(diag_mat(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        m = '1;
        send_mat(m);
        m = {9{32'h8000_0000}};
        send_mat(m);
        m = {9{32'h7FFF_FFFF}};
        send_mat(m);
        m = {9{32'h5555_5555}};
        send_mat(m);
        m = {9{32'hAAAA_AAAA}};
        send_mat(m);
        repeat (4) send_mat(rand_rotation());
        go_idle();
    endtask

    // Hold the source until the pipe drains completely.
    task automatic test_drain_pause();
        go_idle();
        while (quat_fifo.size() != 0) @(posedge i_clk);
        repeat (8) send_mat(rand_rotation());
    endtask

    task automatic test_random(int n);
        repeat (n) begin
            if ($urandom_range(0, 3) != 0) send_mat(rand_rotation());
            else send_mat(rand_mat());
        end
    endtask

    task automatic test_back_to_back(int n);
        no_idle = 1'b1;
        repeat (n) send_mat(($urandom_range(0, 1) != 0) ? rand_rotation() : rand_mat());
        go_idle();
    endtask

    // Sink side: random stall bursts, off in the flat-out phase.
    always @(posedge i_clk) begin
        if (!sink_on) begin
            i_out_ready <= 1'b0;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
            sink_stall  <= 0;
        end else if (sink_stall > 0) begin
            i_out_ready <= (sink_stall == 1);
            sink_stall  <= sink_stall - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_ready <= 1'b0;
            sink_stall  <= $urandom_range(1, 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Result check against the oldest prediction.
    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_out++;
            if (quat_fifo.size() == 0) begin
                $display("%0t: unexpected quaternion beat %h", $time, o_out_data);
                mismatch_cnt++;
            end else begin
                exp_q = quat_fifo.pop_front();
                if (o_out_data.quat_x !== exp_q.quat_x) begin
                    $display("%0t: quat_x exp %h got %h", $time, exp_q.quat_x,
                             o_out_data.quat_x);
                    mismatch_cnt++;
                end
                if (o_out_data.quat_y !== exp_q.quat_y) begin
                    $display("%0t: quat_y exp %h got %h", $time, exp_q.quat_y,
                             o_out_data.quat_y);
                    mismatch_cnt++;
                end
                if (o_out_data.quat_z !== exp_q.quat_z) begin
                    $display("%0t: quat_z exp %h got %h", $time, exp_q.quat_z,
                             o_out_data.quat_z);
                    mismatch_cnt++;
                end
                if (o_out_data.quat_w !== exp_q.quat_w) begin
                    $display("%0t: quat_w exp %h got %h", $time, exp_q.quat_w,
                             o_out_data.quat_w);
                    mismatch_cnt++;
                end
                if (o_out_data.divide_error !== exp_q.divide_error) begin
                    $display("%0t: divide_error exp %b got %b", $time,
                             exp_q.divide_error, o_out_data.divide_error);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: cycles without any accepted beat on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain_pause();
        test_random(1200);
        test_back_to_back(220);
        while (quat_fifo.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        $display("Covered %0d matrices (directed extremes, all four branches, diagonal ties,",
                 beats_in);
        $display("rotations and raw patterns) with %0d quaternions checked.", beats_out);
        if (mismatch_cnt == 0 && quat_fifo.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
